FILE: src/slc_pkg.sv
// Shared types, character codes and classification functions of the slide markup line classifier.
`timescale 1ns / 1ps
`default_nettype none

package slc_pkg;

   // Leading space counter saturates here
   localparam int MAX_INDENT   = 255;
   localparam int SPACE_W      = $clog2(MAX_INDENT + 1);
   localparam int SUM_W        = SPACE_W + 1;
   localparam int HEADING_MAX  = 4;
   localparam int LEVEL_MAX    = 127;
   localparam int SKIP_MAX     = 255;

   // Run queue between front and back
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Results per run: held bytes before and after, one middle result, one final descriptor
   localparam int STEP_W       = 3;
   localparam int TOTAL_W      = 4;

   // Character codes
   localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
   localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
   localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
   localparam logic [7:0] CH_NL    = 8'h0A;  // newline
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;

   // Delimiter match counts
   localparam logic [1:0] HELD_NONE = 2'd0;
   localparam logic [1:0] HELD_ONE  = 2'd1;
   localparam logic [1:0] HELD_MAX  = 2'd3;

   // Element kinds
   localparam logic [1:0] KIND_PARAGRAPH = 2'd0;
   localparam logic [1:0] KIND_HEADING   = 2'd1;
   localparam logic [1:0] KIND_BULLET    = 2'd2;

   typedef struct packed {
      logic [SPACE_W-1:0] spaces;
      logic [2:0]         hashes;
      logic               hash_lead;
      logic               in_leading;
      logic               decided;
      logic [1:0]         kind;
      logic [6:0]         level;
   } elem_state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] level;
      logic [7:0] skip;
      logic       slide_end;
   } desc_type;

   typedef enum logic [1:0] {
      MID_NONE = 2'd0,
      MID_BYTE = 2'd1,
      MID_DESC = 2'd2
   } mid_type;

   // All results caused by one input transfer, in compact form
   typedef struct packed {
      logic [1:0] pre_held;
      mid_type    mid;
      logic [7:0] mid_byte;
      desc_type   mid_desc;
      logic [1:0] post_held;
      logic       final_en;
      desc_type   final_desc;
   } run_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_descriptor;
      logic [1:0] element_kind;
      logic [6:0] element_level;
      logic [7:0] markup_skip;
      logic       end_of_slide;
      logic       last_of_run;
   } result_type;

   function automatic logic [7:0] delim_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = CH_LT;
         2'd1:    c = CH_EQ;
         2'd2:    c = CH_EQ;
         default: c = CH_GT;
      endcase
      return c;
   endfunction

   function automatic elem_state_type elem_clear();
      elem_state_type s;
      s            = '0;
      s.in_leading = 1'b1;
      s.kind       = KIND_PARAGRAPH;
      return s;
   endfunction

   function automatic elem_state_type decide(input elem_state_type s, input logic [1:0] kind,
                                             input logic [6:0] level);
      elem_state_type n;
      n         = s;
      n.decided = 1'b1;
      n.kind    = kind;
      n.level   = level;
      return n;
   endfunction

   // Released delimiter bytes start with '<', which forces a paragraph
   function automatic elem_state_type release_held(input elem_state_type s);
      elem_state_type n;
      n = s;
      if (!s.decided) begin
         n            = decide(s, KIND_PARAGRAPH, 7'd0);
         n.in_leading = 1'b0;
      end
      return n;
   endfunction

   function automatic logic is_bullet_mark(input logic [7:0] c);
      return c inside {CH_STAR, CH_DASH, CH_PLUS};
   endfunction

   // Advance the element classification by one passed-through byte
   function automatic elem_state_type classify(input elem_state_type s, input logic [7:0] c);
      logic [SPACE_W-1:0] half;
      elem_state_type     n;
      n    = s;
      half = s.spaces >> 1;
      if (!s.decided) begin
         if (s.in_leading) begin
            if (c == CH_SPACE) begin
               if (s.spaces != SPACE_W'(MAX_INDENT)) begin
                  n.spaces = s.spaces + 1'b1;
               end
            end else begin
               n.in_leading = 1'b0;
               n.hash_lead  = (c == CH_HASH);
               if (c == CH_HASH) begin
                  n.hashes = 3'd1;
               end else if (!is_bullet_mark(c)) begin
                  n = decide(n, KIND_PARAGRAPH, 7'd0);
               end
            end
         end else if (s.hash_lead) begin
            if (c == CH_HASH) begin
               n.hashes = s.hashes + 3'd1;
               if (n.hashes > 3'(HEADING_MAX)) begin
                  n = decide(n, KIND_PARAGRAPH, 7'd0);
               end
            end else if (c == CH_SPACE) begin
               n = decide(n, KIND_HEADING, 7'(s.hashes));
            end else begin
               n = decide(n, KIND_PARAGRAPH, 7'd0);
            end
         end else if (c == CH_SPACE) begin
            n = decide(n, KIND_BULLET, (int'(half) > LEVEL_MAX) ? 7'(LEVEL_MAX) : 7'(half));
         end else begin
            n = decide(n, KIND_PARAGRAPH, 7'd0);
         end
      end
      return n;
   endfunction

   // Build the closing descriptor of the current element
   function automatic desc_type describe(input elem_state_type s, input logic slide_end);
      desc_type         d;
      logic [SUM_W-1:0] sum;
      d.kind      = s.decided ? s.kind : KIND_PARAGRAPH;
      d.level     = s.decided ? s.level : 7'd0;
      d.slide_end = slide_end;
      case (d.kind)
         KIND_HEADING: sum = SUM_W'(s.spaces) + SUM_W'(s.hashes) + SUM_W'(1);
         KIND_BULLET:  sum = SUM_W'(s.spaces) + SUM_W'(2);
         default:      sum = '0;
      endcase
      d.skip = (int'(sum) > SKIP_MAX) ? 8'(SKIP_MAX) : 8'(sum);
      return d;
   endfunction

   function automatic logic [TOTAL_W-1:0] run_total(input run_type r);
      return TOTAL_W'(r.pre_held) + TOTAL_W'(r.mid != MID_NONE)
           + TOTAL_W'(r.post_held) + TOTAL_W'(r.final_en);
   endfunction

endpackage

`default_nettype wire

FILE: src/slc_req_if.sv
// Input channel of the slide markup line classifier: one text byte per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface slc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       has_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output has_byte, output end_of_text,
                   input ready);
   modport sink   (input valid, input text_byte, input has_byte, input end_of_text,
                   output ready);
endinterface

`default_nettype wire

FILE: src/slc_rsp_if.sv
// Result channel of the slide markup line classifier: element bytes and descriptors.
`timescale 1ns / 1ps
`default_nettype none

interface slc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_descriptor;
   logic [1:0] element_kind;
   logic [6:0] element_level;
   logic [7:0] markup_skip;
   logic       end_of_slide;
   logic       last_of_run;

   modport source (output valid, output out_byte, output is_descriptor, output element_kind,
                   output element_level, output markup_skip, output end_of_slide,
                   output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input is_descriptor, input element_kind,
                   input element_level, input markup_skip, input end_of_slide,
                   input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: src/slc_front.sv
// Front end: delimiter matching and element classification, at most one run per input transfer.
`timescale 1ns / 1ps
`default_nettype none

module slc_front (
   input  wire logic        clock,
   input  wire logic        reset,
   slc_req_if.sink          req,
   input  wire logic        queue_full,
   output logic             push,
   output slc_pkg::run_type push_run
);
   import slc_pkg::*;

   logic [1:0]     held_ff, held_in;
   elem_state_type elem_ff, elem_in;
   run_type        run;
   logic           take;
   logic           xfer;

   assign req.ready = !queue_full;
   assign xfer      = req.valid && req.ready;

   // Work out every result of this transfer and the next state
   always_comb begin
      elem_in = elem_ff;
      held_in = held_ff;
      take    = 1'b0;
      run     = '0;
      run.mid = MID_NONE;
      if (req.has_byte) begin
         if (held_ff == HELD_NONE) begin
            if (req.text_byte == CH_LT) begin
               held_in = HELD_ONE;
            end else begin
               take = 1'b1;
            end
         end else if (req.text_byte == delim_char(held_ff)) begin
            if (held_ff == HELD_MAX) begin
               held_in      = HELD_NONE;
               run.mid      = MID_DESC;
               run.mid_desc = describe(elem_ff, 1'b1);
               elem_in      = elem_clear();
            end else begin
               held_in = held_ff + 2'd1;
            end
         end else begin
            // broken delimiter: release held bytes first
            run.pre_held = held_ff;
            elem_in      = release_held(elem_ff);
            if (req.text_byte == CH_LT) begin
               held_in = HELD_ONE;
            end else begin
               held_in = HELD_NONE;
               take    = 1'b1;
            end
         end
      end
      if (take) begin
         if (req.text_byte == CH_NL) begin
            run.mid      = MID_DESC;
            run.mid_desc = describe(elem_in, 1'b0);
            elem_in      = elem_clear();
         end else begin
            run.mid      = MID_BYTE;
            run.mid_byte = req.text_byte;
            elem_in      = classify(elem_in, req.text_byte);
         end
      end
      // end of text: flush held bytes and close the slide
      if (req.end_of_text) begin
         run.post_held = held_in;
         if (held_in != HELD_NONE) begin
            elem_in = release_held(elem_in);
         end
         run.final_en   = 1'b1;
         run.final_desc = describe(elem_in, 1'b1);
         elem_in        = elem_clear();
         held_in        = HELD_NONE;
      end
   end

   assign push     = xfer && (run_total(run) != '0);
   assign push_run = run;

   // Update match and element state on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= HELD_NONE;
         elem_ff <= elem_clear();
      end else if (xfer) begin
         held_ff <= held_in;
         elem_ff <= elem_in;
      end
   end

   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      (xfer && req.end_of_text) |=> (held_ff == HELD_NONE && elem_ff.in_leading
                                      && !elem_ff.decided))
      else $error("state not cleared after end of text");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("run pushed into full queue");

   a_heading_level: assert property (@(posedge clock) disable iff (reset)
      (elem_ff.decided && elem_ff.kind == KIND_HEADING)
         |-> (elem_ff.level >= 7'd1 && elem_ff.level <= 7'(HEADING_MAX)))
      else $error("heading level out of range");

endmodule

`default_nettype wire

FILE: src/slc_queue.sv
// Run queue that decouples the front end from the result sequencer.
`timescale 1ns / 1ps
`default_nettype none

module slc_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire slc_pkg::run_type push_run,
   input  wire logic             pop,
   output logic                  full,
   output logic                  empty,
   output slc_pkg::run_type      head
);
   import slc_pkg::*;

   run_type           slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slots_ff[rd_ptr_ff];

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed runs
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_run;
      end
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow push");

endmodule

`default_nettype wire

FILE: src/slc_back.sv
// Back end: walks each queued run and drives one result per transfer through an output register.
`timescale 1ns / 1ps
`default_nettype none

module slc_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire slc_pkg::run_type head,
   input  wire logic             empty,
   output logic                  pop,
   slc_rsp_if.source             rsp
);
   import slc_pkg::*;

   logic [STEP_W-1:0]  step_ff, step_in;
   logic               valid_ff, valid_in;
   result_type         result_ff, result_in;
   logic [TOTAL_W-1:0] total;
   logic [TOTAL_W-1:0] pos;
   logic [TOTAL_W-1:0] pre;
   logic [TOTAL_W-1:0] tail;
   logic               mid_en;
   logic               load;
   logic               last;

   assign total  = run_total(head);
   assign pos    = TOTAL_W'(step_ff);
   assign pre    = TOTAL_W'(head.pre_held);
   assign mid_en = (head.mid != MID_NONE);
   assign tail   = pos - pre - TOTAL_W'(mid_en);
   assign load   = !empty && (!valid_ff || rsp.ready);
   assign last   = (pos == total - TOTAL_W'(1));
   assign pop    = load && last;

   // Select the result at the current step of the head run
   always_comb begin
      result_in             = '0;
      result_in.last_of_run = last;
      if (pos < pre) begin
         result_in.out_byte = delim_char(step_ff[1:0]);
      end else if (mid_en && pos == pre) begin
         case (head.mid)
            MID_BYTE: begin
               result_in.out_byte = head.mid_byte;
            end
            MID_DESC: begin
               result_in.is_descriptor = 1'b1;
               result_in.element_kind  = head.mid_desc.kind;
               result_in.element_level = head.mid_desc.level;
               result_in.markup_skip   = head.mid_desc.skip;
               result_in.end_of_slide  = head.mid_desc.slide_end;
            end
            default: begin
               result_in.out_byte = '0;
            end
         endcase
      end else if (tail < TOTAL_W'(head.post_held)) begin
         result_in.out_byte = delim_char(tail[1:0]);
      end else begin
         result_in.is_descriptor = 1'b1;
         result_in.element_kind  = head.final_desc.kind;
         result_in.element_level = head.final_desc.level;
         result_in.markup_skip   = head.final_desc.skip;
         result_in.end_of_slide  = head.final_desc.slide_end;
      end
   end

   // Step through the run, hold the output until it is taken
   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      if (load) begin
         step_in  = last ? '0 : step_ff + 1'b1;
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.out_byte      = result_ff.out_byte;
   assign rsp.is_descriptor = result_ff.is_descriptor;
   assign rsp.element_kind  = result_ff.element_kind;
   assign rsp.element_level = result_ff.element_level;
   assign rsp.markup_skip   = result_ff.markup_skip;
   assign rsp.end_of_slide  = result_ff.end_of_slide;
   assign rsp.last_of_run   = result_ff.last_of_run;

   a_step_in_run: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (pos < total))
      else $error("step beyond end of run");

   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      empty |-> (step_ff == '0))
      else $error("step not at start while queue empty");

   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp.valid && rsp.last_of_run))
      else $error("run ended without last-of-run result");

endmodule

`default_nettype wire

FILE: src/slide_markup_line_classifier.sv
// Top level of the slide markup line classifier: front end, run queue and result sequencer.
// The first result of a transfer is stored in the run queue and then in the result register before
// it is valid on rsp_ch, when the queue is empty and the result register is free.
// Throughput: one input transfer per cycle while req_ch.ready is high; an item that causes n results
// holds the result register until all n are taken, and a four-run queue absorbs these bursts before req_ch.ready drops.
// Reset: synchronous, active high; clears delimiter match, element state, queue and output
// valid at once, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module slide_markup_line_classifier (
   input  wire logic clock,
   input  wire logic reset,
   slc_req_if.sink   req_ch,
   slc_rsp_if.source rsp_ch
);
   import slc_pkg::*;

   logic    push;
   run_type push_run;
   logic    pop;
   logic    full;
   logic    empty;
   run_type head;

   slc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .queue_full (full),
      .push       (push),
      .push_run   (push_run)
   );

   slc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_run (push_run),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head     (head)
   );

   slc_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .empty (empty),
      .pop   (pop),
      .rsp   (rsp_ch)
   );

endmodule

`default_nettype wire
